// File: rtl/dual_channel_pid_speed_loop_unit_defines.svh
// Assertion macros shared by the speed loop RTL.
// Needs a clock named i_clk and an active low reset named i_rst_n in scope.
`ifndef DUAL_CHANNEL_PID_SPEED_LOOP_UNIT_DEFINES_SVH
`define DUAL_CHANNEL_PID_SPEED_LOOP_UNIT_DEFINES_SVH

// Condition must hold at every edge out of reset.
`define DCPID_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define DCPID_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/dcpid_pkg.sv
// Types, register codes and reset constants for the two motor speed loop.
// No dependencies; used by every RTL module of the block.
package dcpid_pkg;

    localparam int GAIN_W  = 48;
    localparam int SPEED_W = 16;
    localparam int INTEG_W = 32;
    localparam int LIMIT_W = 15;
    localparam int CFG_W   = GAIN_W;
    localparam int CFG_IDX_W = 3;

    localparam logic [GAIN_W-1:0]  KP_RESET    = 48'd34359738;
    localparam logic [GAIN_W-1:0]  KI_RESET    = 48'd0;
    localparam logic [GAIN_W-1:0]  KD_RESET    = 48'd42950;
    localparam logic [SPEED_W-1:0] THR_RESET   = 16'd100;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd1400;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP_A  = 3'd0,
        CFG_KI_A  = 3'd1,
        CFG_KD_A  = 3'd2,
        CFG_KP_B  = 3'd3,
        CFG_KI_B  = 3'd4,
        CFG_KD_B  = 3'd5,
        CFG_THR   = 3'd6,
        CFG_LIMIT = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [SPEED_W-1:0] target_speed;
        logic signed [SPEED_W-1:0] measured_speed;
        logic                      motor_select;
    } t_in_beat;

    typedef struct packed {
        logic signed [SPEED_W-1:0] drive;
        logic                      clamped;
    } t_out_beat;

    typedef struct packed {
        logic signed [GAIN_W-1:0]  kp_a;
        logic signed [GAIN_W-1:0]  ki_a;
        logic signed [GAIN_W-1:0]  kd_a;
        logic signed [GAIN_W-1:0]  kp_b;
        logic signed [GAIN_W-1:0]  ki_b;
        logic signed [GAIN_W-1:0]  kd_b;
        logic signed [SPEED_W-1:0] threshold;
        logic        [LIMIT_W-1:0] limit;
    } t_cfg;

    // Operands of the three gain products for one beat.
    typedef struct packed {
        logic signed [GAIN_W-1:0]  kp;
        logic signed [GAIN_W-1:0]  ki;
        logic signed [GAIN_W-1:0]  kd;
        logic signed [SPEED_W:0]   err;
        logic signed [INTEG_W-1:0] sum;
        logic signed [SPEED_W:0]   delta;
    } t_term_ops;

endpackage

// File: rtl/dcpid_cfg_regs.sv
// Configuration register file: gains, integrator clear threshold, output limit.
// Depends on dcpid_pkg.
module dcpid_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dcpid_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [dcpid_pkg::CFG_W-1:0]     i_cfg_data,
    output dcpid_pkg::t_cfg                 o_cfg
);
    import dcpid_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_KP_A:  n_cfg.kp_a      = i_cfg_data;
                CFG_KI_A:  n_cfg.ki_a      = i_cfg_data;
                CFG_KD_A:  n_cfg.kd_a      = i_cfg_data;
                CFG_KP_B:  n_cfg.kp_b      = i_cfg_data;
                CFG_KI_B:  n_cfg.ki_b      = i_cfg_data;
                CFG_KD_B:  n_cfg.kd_b      = i_cfg_data;
                CFG_THR:   n_cfg.threshold = i_cfg_data[SPEED_W-1:0];
                CFG_LIMIT: n_cfg.limit     = i_cfg_data[LIMIT_W-1:0];
                default:   n_cfg           = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp_a      <= KP_RESET;
            r_cfg.ki_a      <= KI_RESET;
            r_cfg.kd_a      <= KD_RESET;
            r_cfg.kp_b      <= KP_RESET;
            r_cfg.ki_b      <= KI_RESET;
            r_cfg.kd_b      <= KD_RESET;
            r_cfg.threshold <= THR_RESET;
            r_cfg.limit     <= LIMIT_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/dcpid_front.sv
// Per-motor state (integrators, previous speed) and error/derivative front end.
// Registers the product operands for the multiplier stage. Depends on dcpid_pkg.
module dcpid_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  dcpid_pkg::t_in_beat  i_beat,
    input  dcpid_pkg::t_cfg      i_cfg,
    output dcpid_pkg::t_term_ops o_ops
);
    import dcpid_pkg::*;

    logic signed [INTEG_W-1:0] r_integ [2];
    logic signed [SPEED_W-1:0] r_prev  [2];
    t_term_ops                 r_ops;

    logic                      clr;
    logic                      sel;
    logic signed [SPEED_W:0]   err;
    logic signed [SPEED_W:0]   delta;
    logic signed [INTEG_W-1:0] base;
    logic signed [INTEG_W:0]   sum_w;
    logic signed [INTEG_W-1:0] sum_sat;
    t_term_ops                 n_ops;

    localparam logic signed [INTEG_W:0] SUM_MAX = {2'b00, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W:0] SUM_MIN = {2'b11, {(INTEG_W-1){1'b0}}};

    always_comb begin
        sel   = i_beat.motor_select;
        clr   = i_beat.target_speed < i_cfg.threshold;
        err   = {i_beat.target_speed[SPEED_W-1], i_beat.target_speed}
              - {i_beat.measured_speed[SPEED_W-1], i_beat.measured_speed};
        delta = {i_beat.measured_speed[SPEED_W-1], i_beat.measured_speed}
              - {r_prev[sel][SPEED_W-1], r_prev[sel]};
        base  = clr ? '0 : r_integ[sel];
        sum_w = {base[INTEG_W-1], base} + (INTEG_W+1)'(err);
        // saturate to the 32 bit signed range
        if (sum_w > SUM_MAX) begin
            sum_sat = SUM_MAX[INTEG_W-1:0];
        end else if (sum_w < SUM_MIN) begin
            sum_sat = SUM_MIN[INTEG_W-1:0];
        end else begin
            sum_sat = sum_w[INTEG_W-1:0];
        end
        n_ops.kp    = sel ? i_cfg.kp_b : i_cfg.kp_a;
        n_ops.ki    = sel ? i_cfg.ki_b : i_cfg.ki_a;
        n_ops.kd    = sel ? i_cfg.kd_b : i_cfg.kd_a;
        n_ops.err   = err;
        n_ops.sum   = sum_sat;
        n_ops.delta = delta;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ[0] <= '0;
            r_integ[1] <= '0;
            r_prev[0]  <= '0;
            r_prev[1]  <= '0;
        end else if (i_load) begin
            if (clr) begin
                r_integ[!sel] <= '0;
            end
            r_integ[sel] <= sum_sat;
            r_prev[sel]  <= i_beat.measured_speed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ops <= n_ops;
        end
    end

    assign o_ops = r_ops;

endmodule

// File: rtl/dcpid_term_mul.sv
// One gain product split at bit 32 of the gain: a signed high part and an
// unsigned low part, both registered. Depends on dcpid_pkg.
module dcpid_term_mul (
    input  logic                                  i_clk,
    input  logic                                  i_load,
    input  logic signed [dcpid_pkg::GAIN_W-1:0]   i_gain,
    input  logic signed [dcpid_pkg::INTEG_W-1:0]  i_x,
    output logic signed [dcpid_pkg::GAIN_W-1:0]   o_hi,
    output logic signed [dcpid_pkg::INTEG_W+32:0] o_lo
);
    import dcpid_pkg::*;

    localparam int HI_W = GAIN_W - 32;

    logic signed [GAIN_W-1:0]    r_hi;
    logic signed [INTEG_W+32:0]  r_lo;
    logic signed [HI_W-1:0]      gain_hi;
    logic signed [32:0]          gain_lo;
    logic signed [GAIN_W-1:0]    n_hi;
    logic signed [INTEG_W+32:0]  n_lo;

    always_comb begin
        gain_hi = i_gain[GAIN_W-1:32];
        gain_lo = $signed({1'b0, i_gain[31:0]});
        n_hi    = gain_hi * i_x;
        n_lo    = gain_lo * i_x;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_hi <= n_hi;
            r_lo <= n_lo;
        end
    end

    assign o_hi = r_hi;
    assign o_lo = r_lo;

endmodule

// File: rtl/dual_channel_pid_speed_loop_unit.sv
// Top level of the two motor PID speed loop with output clamp.
// Depends on dcpid_pkg, dcpid_cfg_regs, dcpid_front, dcpid_term_mul and the defines header.
//
//   channel  direction  handshake              payload
//   input    in         i_valid / o_stall      i_beat  (target, measured, motor)
//   output   out        o_valid / i_stall      o_beat  (drive, clamped)
//   config   in         i_cfg_we               i_cfg_addr, i_cfg_data
//
// Five register stages: input, state and operands, split products, partial sums,
// clamped result. One beat is taken per cycle while the input is not stalled, set by
// the single pass through the per-motor state update.
// Reset clears all valid bits, both integrators, both previous speeds and loads the
// register defaults. Empty stages collapse under an output stall; input stalls
// only once every stage holds a beat.
module dual_channel_pid_speed_loop_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  dcpid_pkg::t_in_beat             i_beat,
    output logic                            o_valid,
    input  logic                            i_stall,
    output dcpid_pkg::t_out_beat            o_beat,
    input  logic                            i_cfg_we,
    input  logic [dcpid_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [dcpid_pkg::CFG_W-1:0]     i_cfg_data
);
    import dcpid_pkg::*;
    `include "dual_channel_pid_speed_loop_unit_defines.svh"

    localparam int NSTG  = 5;
    localparam int LO_W  = INTEG_W + 33;
    localparam int LOS_W = LO_W + 2;
    localparam int HIS_W = GAIN_W + 2;
    localparam int VAL_W = HIS_W + 1;

    t_cfg      cfg;
    t_in_beat  r_s0;
    t_term_ops ops;
    t_out_beat r_out;
    t_out_beat n_out;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] rdy;

    logic signed [GAIN_W-1:0] hi_p, hi_i, hi_d;
    logic signed [LO_W-1:0]   lo_p, lo_i, lo_d;
    logic signed [LOS_W-1:0]  r_lo_sum, n_lo_sum;
    logic signed [HIS_W-1:0]  r_hi_sum, n_hi_sum;
    logic signed [VAL_W-1:0]  val;
    logic signed [VAL_W-1:0]  lim;

    // stage k loads when it is empty or its beat moves on
    always_comb begin
        rdy[NSTG-1] = !r_vld[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_s0 <= i_beat;
        end
    end

    dcpid_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // state only advances for a real beat
    dcpid_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (rdy[1] && r_vld[0]),
        .i_beat  (r_s0),
        .i_cfg   (cfg),
        .o_ops   (ops)
    );

    dcpid_term_mul u_mul_p (
        .i_clk  (i_clk),
        .i_load (rdy[2]),
        .i_gain (ops.kp),
        .i_x    (INTEG_W'(ops.err)),
        .o_hi   (hi_p),
        .o_lo   (lo_p)
    );

    dcpid_term_mul u_mul_i (
        .i_clk  (i_clk),
        .i_load (rdy[2]),
        .i_gain (ops.ki),
        .i_x    (ops.sum),
        .o_hi   (hi_i),
        .o_lo   (lo_i)
    );

    dcpid_term_mul u_mul_d (
        .i_clk  (i_clk),
        .i_load (rdy[2]),
        .i_gain (ops.kd),
        .i_x    (INTEG_W'(ops.delta)),
        .o_hi   (hi_d),
        .o_lo   (lo_d)
    );

    always_comb begin
        n_lo_sum = LOS_W'(lo_p) + LOS_W'(lo_i) + LOS_W'(lo_d);
        n_hi_sum = HIS_W'(hi_p) + HIS_W'(hi_i) + HIS_W'(hi_d);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r_lo_sum <= n_lo_sum;
            r_hi_sum <= n_hi_sum;
        end
    end

    // floor shift by 32: high parts sit at weight 2^32, drop the low 32 bits of the rest
    always_comb begin
        val = VAL_W'(r_hi_sum) + VAL_W'($signed(r_lo_sum[LOS_W-1:32]));
        lim = $signed({{(VAL_W-LIMIT_W){1'b0}}, cfg.limit});
        if (val > lim) begin
            n_out.drive   = $signed({1'b0, cfg.limit});
            n_out.clamped = 1'b1;
        end else if (val < -lim) begin
            n_out.drive   = -$signed({1'b0, cfg.limit});
            n_out.clamped = 1'b1;
        end else begin
            n_out.drive   = val[SPEED_W-1:0];
            n_out.clamped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            r_out <= n_out;
        end
    end

    assign o_stall = !rdy[0];
    assign o_valid = r_vld[NSTG-1];
    assign o_beat  = r_out;

    `DCPID_ASSERT_NEXT(a_in_beat_lands, i_valid && !o_stall, r_vld[0],
        "accepted input beat did not reach the input stage")
    `DCPID_ASSERT_NEXT(a_out_held, o_valid && i_stall, o_valid,
        "stalled output beat was dropped")
    `DCPID_ASSERT_ALWAYS(a_stall_only_full, !o_stall || (&r_vld),
        "input stalled while a pipeline stage was empty")

endmodule
